FILE: hw/rtl/deadlock_avoidance_resource_granter_defines.svh
// Assertion macros for the resource granter.
`ifndef DEADLOCK_AVOIDANCE_RESOURCE_GRANTER_DEFINES_SVH
`define DEADLOCK_AVOIDANCE_RESOURCE_GRANTER_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define DARG_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication.
`define DARG_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

FILE: hw/rtl/darg_pkg.sv
// Shared types and codes of the resource granter.
package darg_pkg;
    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_LOAD_CLAIM = 2'd2;
    localparam logic [1:0] OP_LOAD_AVAIL = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_NEED = 3'd1;
    localparam logic [2:0] ST_AVAIL = 3'd2;
    localparam logic [2:0] ST_UNSAFE = 3'd3;
    localparam logic [2:0] ST_OVER = 3'd4;
    localparam logic [2:0] ST_LOADED = 3'd5;

    localparam int AMOUNT_FIELDS = 4;
    localparam int AMOUNT_BITS = 16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SAFE_INIT,
        S_SAFE_SCAN,
        S_REVERT,
        S_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_item;   // capture the input item
        logic check;       // run need/available/held compare
        logic apply;       // apply item to tables
        logic safe_init;   // copy available into pool, clear done bits
        logic safe_step;   // examine one customer
        logic revert;      // undo tentative request
        logic set_status;  // latch status code
        logic [2:0] status;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] op;
        logic known;
        logic fail_need;
        logic fail_avail;
        logic fail_over;
        logic scan_end;    // scan finished: safe or no progress possible
        logic safe;
    } dp_stat_t;
endpackage

FILE: hw/rtl/darg_datapath.sv
// Tables, compare logic and safety-check pool of the resource granter.
module darg_datapath #(
    parameter int NUM_RESOURCES = 4,
    parameter int NUM_CUSTOMERS = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic [darg_pkg::AMOUNT_FIELDS*darg_pkg::AMOUNT_BITS+4:0] item,
    input  darg_pkg::dp_cmd_t cmd,
    output darg_pkg::dp_stat_t stat,
    output logic [2:0] status,
    output logic [2:0] cust_out
);
    import darg_pkg::*;
    localparam int CB = (NUM_CUSTOMERS > 1) ? $clog2(NUM_CUSTOMERS) : 1;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] avail_reg [NUM_RESOURCES];
    logic [COUNT_BITS-1:0] alloc_reg [NUM_CUSTOMERS][NUM_RESOURCES];
    logic [COUNT_BITS-1:0] need_reg [NUM_CUSTOMERS][NUM_RESOURCES];
    logic [COUNT_BITS-1:0] pool_reg [NUM_RESOURCES];
    logic [NUM_CUSTOMERS-1:0] done_reg;
    logic [CB-1:0] idx_reg;
    logic progress_reg;
    logic [1:0] op_reg;
    logic [2:0] cust_reg;
    logic [AMOUNT_BITS-1:0] amt_reg [NUM_RESOURCES];
    logic [2:0] status_reg;

    logic known;
    logic [CB-1:0] ci;
    logic [AMOUNT_BITS-1:0] amt_in [NUM_RESOURCES];
    logic [COUNT_BITS-1:0] amtc [NUM_RESOURCES];
    logic [COUNT_BITS:0] amtw [NUM_RESOURCES];
    logic fneed, favail, fover, fits, last_idx, all_done;

    always_comb
    begin
        for (int r = 0; r < NUM_RESOURCES; r++)
        begin
            if (r < AMOUNT_FIELDS)
                amt_in[r] = item[5 + r*AMOUNT_BITS +: AMOUNT_BITS];
            else
                amt_in[r] = '0;
        end
    end

    assign known = (32'(cust_reg) < 32'(NUM_CUSTOMERS));
    assign ci = CB'(cust_reg);

    // saturated amount in count width, plus zero-extended wide form
    always_comb
    begin
        for (int r = 0; r < NUM_RESOURCES; r++)
        begin
            if (COUNT_BITS >= AMOUNT_BITS)
                amtw[r] = (COUNT_BITS+1)'(amt_reg[r]);
            else
                amtw[r] = (COUNT_BITS+1)'(amt_reg[r] > AMOUNT_BITS'(CMAX) ? AMOUNT_BITS'(CMAX)
                                                                          : amt_reg[r]);
            amtc[r] = (amt_reg[r] > AMOUNT_BITS'(CMAX)) ? CMAX : amtw[r][COUNT_BITS-1:0];
        end
    end

    always_comb
    begin
        fneed = 1'b0;
        favail = 1'b0;
        fover = 1'b0;
        for (int r = 0; r < NUM_RESOURCES; r++)
        begin
            // compare in 32-bit width (widen both sides)
            if (32'(amt_reg[r]) > (known ? 32'(need_reg[ci][r]) : 32'd0))
                fneed = 1'b1;
            if (32'(amt_reg[r]) > 32'(avail_reg[r]))
                favail = 1'b1;
            if (32'(amt_reg[r]) > (known ? 32'(alloc_reg[ci][r]) : 32'd0))
                fover = 1'b1;
        end
        fits = !done_reg[idx_reg];
        for (int r = 0; r < NUM_RESOURCES; r++)
            if (need_reg[idx_reg][r] > pool_reg[r])
                fits = 1'b0;
    end

    assign last_idx = (idx_reg == CB'(NUM_CUSTOMERS - 1));
    assign all_done = &(done_reg | ({NUM_CUSTOMERS{1'b0}} | (fits ? (NUM_CUSTOMERS'(1) << idx_reg)
                                                                  : '0)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_RESOURCES; r++)
            begin
                avail_reg[r] <= '0;
                for (int c = 0; c < NUM_CUSTOMERS; c++)
                begin
                    alloc_reg[c][r] <= '0;
                    need_reg[c][r] <= '0;
                end
            end
            done_reg <= '0;
            idx_reg <= '0;
            progress_reg <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            if (cmd.set_status)
                status_reg <= cmd.status;
            if (cmd.apply)
            begin
                for (int r = 0; r < NUM_RESOURCES; r++)
                begin
                    case (op_reg)
                        OP_REQUEST:
                        begin
                            if (known)
                            begin
                                avail_reg[r] <= avail_reg[r] - amtc[r];
                                alloc_reg[ci][r] <= alloc_reg[ci][r] + amtc[r];
                                need_reg[ci][r] <= need_reg[ci][r] - amtc[r];
                            end
                        end
                        OP_RELEASE:
                        begin
                            if (known)
                            begin
                                avail_reg[r] <= ((avail_reg[r] + amtw[r]) > (COUNT_BITS+1)'(CMAX))
                                    ? CMAX : COUNT_BITS'(avail_reg[r] + amtw[r]);
                                alloc_reg[ci][r] <= alloc_reg[ci][r] - amtc[r];
                                need_reg[ci][r] <= ((need_reg[ci][r] + amtw[r])
                                    > (COUNT_BITS+1)'(CMAX))
                                    ? CMAX : COUNT_BITS'(need_reg[ci][r] + amtw[r]);
                            end
                        end
                        OP_LOAD_CLAIM:
                        begin
                            if (known)
                                need_reg[ci][r] <= (amtc[r] > alloc_reg[ci][r])
                                    ? amtc[r] - alloc_reg[ci][r] : '0;
                        end
                        default:
                            avail_reg[r] <= amtc[r];
                    endcase
                end
            end
            if (cmd.revert && known)
            begin
                for (int r = 0; r < NUM_RESOURCES; r++)
                begin
                    avail_reg[r] <= avail_reg[r] + amtc[r];
                    alloc_reg[ci][r] <= alloc_reg[ci][r] - amtc[r];
                    need_reg[ci][r] <= need_reg[ci][r] + amtc[r];
                end
            end
            if (cmd.safe_init)
            begin
                done_reg <= '0;
                idx_reg <= '0;
                progress_reg <= 1'b0;
            end
            else if (cmd.safe_step)
            begin
                if (fits)
                    done_reg[idx_reg] <= 1'b1;
                if (last_idx)
                begin
                    idx_reg <= '0;
                    progress_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                    progress_reg <= progress_reg | fits;
                end
            end
        end
    end

    // pool and item capture: payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg <= item[1:0];
            cust_reg <= item[4:2];
            for (int r = 0; r < NUM_RESOURCES; r++)
                amt_reg[r] <= amt_in[r];
        end
        for (int r = 0; r < NUM_RESOURCES; r++)
        begin
            if (cmd.safe_init)
                pool_reg[r] <= avail_reg[r];
            else if (cmd.safe_step && fits)
                pool_reg[r] <= ((COUNT_BITS+1)'(pool_reg[r])
                                + (COUNT_BITS+1)'(alloc_reg[idx_reg][r])
                                > (COUNT_BITS+1)'(CMAX))
                    ? CMAX : pool_reg[r] + alloc_reg[idx_reg][r];
        end
    end

    always_comb
    begin
        stat.op = op_reg;
        stat.known = known;
        stat.fail_need = fneed;
        stat.fail_avail = favail;
        stat.fail_over = fover;
        stat.safe = all_done;
        stat.scan_end = cmd.safe_step && (all_done || (last_idx && !(progress_reg || fits)));
    end

    assign status = status_reg;
    assign cust_out = cust_reg;
endmodule

FILE: hw/rtl/darg_controller.sv
// Sequencing state machine of the resource granter.
module darg_controller (
    input  logic clk,
    input  logic rst_n,
    input  logic in_fire,
    input  logic out_fire,
    input  darg_pkg::dp_stat_t stat,
    output darg_pkg::dp_cmd_t cmd,
    output logic busy,
    output logic out_valid
);
    import darg_pkg::*;
    `include "deadlock_avoidance_resource_granter_defines.svh"

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_fire)
                    state_next = S_CHECK;
            S_CHECK:
            begin
                if (stat.op == OP_REQUEST && !stat.fail_need && !stat.fail_avail)
                    state_next = S_SAFE_INIT;
                else
                    state_next = S_DONE;
            end
            S_SAFE_INIT:
                state_next = S_SAFE_SCAN;
            S_SAFE_SCAN:
                if (stat.scan_end)
                    state_next = stat.safe ? S_DONE : S_REVERT;
            S_REVERT:
                state_next = S_DONE;
            S_DONE:
                if (out_fire)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:
                cmd.load_item = in_fire;
            S_CHECK:
            begin
                cmd.set_status = 1'b1;
                case (stat.op)
                    OP_REQUEST:
                    begin
                        cmd.status = stat.fail_need ? ST_NEED
                                   : (stat.fail_avail ? ST_AVAIL : ST_OK);
                        cmd.apply = !stat.fail_need && !stat.fail_avail;
                    end
                    OP_RELEASE:
                    begin
                        cmd.status = stat.fail_over ? ST_OVER : ST_OK;
                        cmd.apply = !stat.fail_over;
                    end
                    default:
                    begin
                        cmd.status = ST_LOADED;
                        cmd.apply = 1'b1;
                    end
                endcase
            end
            S_SAFE_INIT:
                cmd.safe_init = 1'b1;
            S_SAFE_SCAN:
                cmd.safe_step = 1'b1;
            S_REVERT:
            begin
                cmd.revert = 1'b1;
                cmd.set_status = 1'b1;
                cmd.status = ST_UNSAFE;
            end
            default:
                cmd = '0;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_DONE);

    `DARG_ASSERT_IMP(a_no_fire_busy, clk, rst_n, busy, !in_fire)
    `DARG_ASSERT_NXT(a_fire_check, clk, rst_n, in_fire, state_reg == S_CHECK)
    `DARG_ASSERT_NXT(a_revert_done, clk, rst_n, state_reg == S_REVERT, out_valid)
    `DARG_ASSERT_IMP(a_scan_cmd, clk, rst_n, cmd.safe_step, !cmd.apply && !cmd.revert)
endmodule

FILE: hw/rtl/deadlock_avoidance_resource_granter.sv
// Top level of the banker's-algorithm resource granter.
// One item at a time: a release, a load or a request that fails the need or available
// check goes through the CHECK and DONE states; a request that passes both checks runs
// the safety scan, one customer per cycle, in passes over the customer table while any
// customer can finish, then goes to DONE or, if unsafe, through REVERT to DONE.
// The result waits in its register until taken; a new item is accepted only after.
module deadlock_avoidance_resource_granter #(
    parameter int NUM_RESOURCES = 4,
    parameter int NUM_CUSTOMERS = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [71:0] s_tdata,   // operation[1:0], customer[4:2], amount_0..3 [68:5], zero pad
    output logic m_tvalid,
    input  logic m_tready,
    output logic [7:0] m_tdata     // status[2:0], echo_customer[5:3], zero pad
);
    import darg_pkg::*;

    dp_cmd_t cmd;
    dp_stat_t stat;
    logic busy, in_fire, out_fire;
    logic [2:0] status, cust;

    assign s_tready = !busy;
    assign in_fire = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    darg_controller u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
        .stat(stat), .cmd(cmd), .busy(busy), .out_valid(m_tvalid)
    );

    darg_datapath #(
        .NUM_RESOURCES(NUM_RESOURCES), .NUM_CUSTOMERS(NUM_CUSTOMERS),
        .COUNT_BITS(COUNT_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .item(s_tdata[68:0]), .cmd(cmd), .stat(stat),
        .status(status), .cust_out(cust)
    );

    assign m_tdata = {2'b00, cust, status};
endmodule
